>>> sv/bqra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block queue package
// Transfer types, operation kinds and status codes used by the block queue
// core; its storage RAM is generic and does not import this package.
// ----------------------------------------------------------------------------
package bqra_pkg;

   // Operation kinds carried in a request.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  block_id;
      logic [31:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_block_id;
      logic [31:0] out_block_addr;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [7:0]  block_id;
      logic [31:0] block_addr;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> sv/bqra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bqra_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/block_queue_with_remove_by_address_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block queue with remove by address
// Ordered queue of block descriptors with insert at the back, remove at the
// front, and remove of the oldest entry that matches a given address.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Every request produces exactly one result, shown on rsp_item for a single
// cycle while rsp_valid is high; the receiver cannot stall, so it must take
// the result in that cycle. Inserts, requests on an empty queue and unknown
// kinds finish in the cycle of the transfer: busy stays low and the result
// appears in the next cycle. A remove at the front passes through ST_POP,
// since the entry comes out of a RAM with a registered read. A remove by
// address walks the queue from the front through the RAM read port and a
// single address comparator, one entry per cycle, and then closes the gap
// by copying every later entry down one place, again one per cycle. The
// entries live in a circular buffer, so no clearing pass runs after reset
// and the queue is ready right away.
// ----------------------------------------------------------------------------
module block_queue_with_remove_by_address_core
   import bqra_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_POP    = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_SHIFT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   req_type          req_ff, req_in;
   entry_type        hit_ff, hit_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic [CNT_W-1:0] pos_ext;

   // Map a position counted from the front to its slot in the ring.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_DEPTH) begin
         sum = sum - SUM_DEPTH;
      end
      return sum[IDX_W-1:0];
   endfunction

   bqra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos_ext = CNT_W'(pos_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, count_ff);
      wr_data      = '{block_id: req_item.block_id, block_addr: req_item.block_addr};
      rd_addr      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               rsp_in = '{status: STATUS_MISS, out_block_id: '0, out_block_addr: '0};
               case (req_item.kind)
                  KIND_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        // Append in the slot just past the newest entry.
                        wr_en         = 1'b1;
                        count_in      = count_ff + 1'b1;
                        rsp_in.status = STATUS_DONE;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        pos_in   = '0;
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_POP: begin
            // The front entry read in the previous cycle is now on rd_data.
            rsp_valid_in = 1'b1;
            rsp_in = '{status: STATUS_DONE, out_block_id: rd_data.block_id,
                       out_block_addr: rd_data.block_addr};
            head_in  = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = ST_IDLE;
         end

         ST_SEARCH: begin
            // rd_data holds the entry at position pos_ff.
            rd_addr = slot_of(head_ff, pos_ext + 1'b1);
            if (rd_data.block_addr == req_ff.block_addr) begin
               hit_in = rd_data;
               if (pos_ext + 1'b1 == count_ff) begin
                  // The newest entry matched: nothing behind it to move.
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: STATUS_DONE, out_block_id: rd_data.block_id,
                             out_block_addr: rd_data.block_addr};
                  count_in = count_ff - 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else if (pos_ext + 1'b1 == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STATUS_MISS, out_block_id: '0, out_block_addr: '0};
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         ST_SHIFT: begin
            // rd_data holds the entry at position pos_ff + 1; move it down one.
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, pos_ext);
            wr_data = rd_data;
            rd_addr = slot_of(head_ff, pos_ext + 2'd2);
            if (pos_ext + 2'd2 == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STATUS_DONE, out_block_id: hit_ff.block_id,
                          out_block_addr: hit_ff.block_addr};
               count_in = count_ff - 1'b1;
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      req_ff <= req_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The fill level never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill level above depth");

   // A refused insert only happens on a full queue.
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_FULL |-> $past(count_ff) == CNT_FULL)
      else $error("insert refused on a queue that was not full");

   // A successful removal takes exactly one entry out.
   a_remove_decrements: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_DONE && req_ff.kind != KIND_INSERT
      |-> count_ff == $past(count_ff) - 1'b1)
      else $error("removal did not take exactly one entry");

   // Failed results (miss or full) carry zero payload.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_DONE
      |-> rsp_ff.out_block_id == '0 && rsp_ff.out_block_addr == '0)
      else $error("nonzero payload on a failed request");

endmodule
